// ===== src/sesq_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI EEPROM sequencer package
// Shared types, command codes and the per-job result sequence tables.
// ----------------------------------------------------------------------------
`default_nettype none

package sesq_pkg;

  localparam int PAGE_BYTES = 64;
  localparam int PAGE_AW    = $clog2(PAGE_BYTES);
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

  localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;

  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRDI  = 8'h04;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_WRSR  = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] DUMMY     = 8'hFF;

  typedef enum logic [2:0] {
    OP_WRITE_REQ = 3'd0,
    OP_READ_REQ  = 3'd1,
    OP_WRSR_REQ  = 3'd2,
    OP_DATA      = 3'd3,
    OP_RX        = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ACT_SEL   = 3'd0,
    ACT_XFER  = 3'd1,
    ACT_DESEL = 3'd2,
    ACT_HOST  = 3'd3,
    ACT_DONE  = 3'd4
  } act_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_WDATA = 4'b0010,
    PH_WPOLL = 4'b0100,
    PH_RDATA = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    JK_DONE,
    JK_WCHUNK,
    JK_RDSTART,
    JK_WRSR,
    JK_WDATA,
    JK_WDATA_END,
    JK_POLL,
    JK_FIN_NEXT,
    JK_FIN_DONE,
    JK_RHOST_MORE,
    JK_RHOST_END
  } job_kind_t;

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_DATA,
    SRC_AHI,
    SRC_ALO
  } src_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        timed_out;
  } job_t;

  typedef struct packed {
    act_t       act;
    src_t       src;
    logic [7:0] cbyte;
    logic       fin;
  } step_t;

  function automatic step_t mk_step(act_t act, src_t src, logic [7:0] cbyte, logic fin);
    step_t s;
    s.act   = act;
    s.src   = src;
    s.cbyte = cbyte;
    s.fin   = fin;
    return s;
  endfunction

  function automatic step_t wchunk_step(logic [3:0] idx);
    step_t s;
    case (idx)
      4'd0: s = mk_step(ACT_SEL, SRC_CONST, 8'h00, 1'b0);
      4'd1: s = mk_step(ACT_XFER, SRC_CONST, CMD_WREN, 1'b0);
      4'd2: s = mk_step(ACT_DESEL, SRC_CONST, 8'h00, 1'b0);
      4'd3: s = mk_step(ACT_SEL, SRC_CONST, 8'h00, 1'b0);
      4'd4: s = mk_step(ACT_XFER, SRC_CONST, CMD_WRITE, 1'b0);
      4'd5: s = mk_step(ACT_XFER, SRC_AHI, 8'h00, 1'b0);
      default: s = mk_step(ACT_XFER, SRC_ALO, 8'h00, 1'b1);
    endcase
    return s;
  endfunction

  function automatic step_t fin_head_step(logic [3:0] idx);
    step_t s;
    case (idx)
      4'd1: s = mk_step(ACT_SEL, SRC_CONST, 8'h00, 1'b0);
      4'd2: s = mk_step(ACT_XFER, SRC_CONST, CMD_WRDI, 1'b0);
      default: s = mk_step(ACT_DESEL, SRC_CONST, 8'h00, 1'b0);
    endcase
    return s;
  endfunction

  function automatic step_t seq_step(job_kind_t kind, logic [3:0] idx);
    step_t s;
    s = mk_step(ACT_DONE, SRC_CONST, 8'h00, 1'b1);
    case (kind)
      JK_DONE: s = mk_step(ACT_DONE, SRC_CONST, 8'h00, 1'b1);
      JK_WCHUNK: s = wchunk_step(idx);
      JK_RDSTART: begin
        case (idx)
          4'd0: s = mk_step(ACT_SEL, SRC_CONST, 8'h00, 1'b0);
          4'd1: s = mk_step(ACT_XFER, SRC_CONST, CMD_READ, 1'b0);
          4'd2: s = mk_step(ACT_XFER, SRC_AHI, 8'h00, 1'b0);
          4'd3: s = mk_step(ACT_XFER, SRC_ALO, 8'h00, 1'b0);
          default: s = mk_step(ACT_XFER, SRC_CONST, DUMMY, 1'b1);
        endcase
      end
      JK_WRSR: begin
        case (idx)
          4'd0: s = mk_step(ACT_SEL, SRC_CONST, 8'h00, 1'b0);
          4'd1: s = mk_step(ACT_XFER, SRC_CONST, CMD_WREN, 1'b0);
          4'd2: s = mk_step(ACT_DESEL, SRC_CONST, 8'h00, 1'b0);
          4'd3: s = mk_step(ACT_SEL, SRC_CONST, 8'h00, 1'b0);
          4'd4: s = mk_step(ACT_XFER, SRC_CONST, CMD_WRSR, 1'b0);
          4'd5: s = mk_step(ACT_XFER, SRC_DATA, 8'h00, 1'b0);
          4'd6: s = mk_step(ACT_DESEL, SRC_CONST, 8'h00, 1'b0);
          4'd7: s = mk_step(ACT_SEL, SRC_CONST, 8'h00, 1'b0);
          4'd8: s = mk_step(ACT_XFER, SRC_CONST, CMD_WRDI, 1'b0);
          4'd9: s = mk_step(ACT_DESEL, SRC_CONST, 8'h00, 1'b0);
          default: s = mk_step(ACT_DONE, SRC_CONST, 8'h00, 1'b1);
        endcase
      end
      JK_WDATA: s = mk_step(ACT_XFER, SRC_DATA, 8'h00, 1'b1);
      JK_WDATA_END: begin
        case (idx)
          4'd0: s = mk_step(ACT_XFER, SRC_DATA, 8'h00, 1'b0);
          4'd1: s = mk_step(ACT_DESEL, SRC_CONST, 8'h00, 1'b0);
          4'd2: s = mk_step(ACT_SEL, SRC_CONST, 8'h00, 1'b0);
          4'd3: s = mk_step(ACT_XFER, SRC_CONST, CMD_RDSR, 1'b0);
          default: s = mk_step(ACT_XFER, SRC_CONST, DUMMY, 1'b1);
        endcase
      end
      JK_POLL: s = mk_step(ACT_XFER, SRC_CONST, DUMMY, 1'b1);
      JK_FIN_NEXT: begin
        if (idx < 4'd4) begin
          s = fin_head_step(idx);
        end else begin
          s = wchunk_step(4'(idx - 4'd4));
        end
      end
      JK_FIN_DONE: begin
        if (idx < 4'd4) begin
          s = fin_head_step(idx);
        end else begin
          s = mk_step(ACT_DONE, SRC_CONST, 8'h00, 1'b1);
        end
      end
      JK_RHOST_MORE: begin
        case (idx)
          4'd0: s = mk_step(ACT_HOST, SRC_DATA, 8'h00, 1'b0);
          default: s = mk_step(ACT_XFER, SRC_CONST, DUMMY, 1'b1);
        endcase
      end
      JK_RHOST_END: begin
        case (idx)
          4'd0: s = mk_step(ACT_HOST, SRC_DATA, 8'h00, 1'b0);
          4'd1: s = mk_step(ACT_DESEL, SRC_CONST, 8'h00, 1'b0);
          default: s = mk_step(ACT_DONE, SRC_CONST, 8'h00, 1'b1);
        endcase
      end
      default: s = mk_step(ACT_DONE, SRC_CONST, 8'h00, 1'b1);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/sesq_front.sv =====
// ----------------------------------------------------------------------------
// SPI EEPROM sequencer front end
// Accepts host words, tracks the request state and classifies each word into
// a job for the back end, or drops it.
// ----------------------------------------------------------------------------
`default_nettype none

module sesq_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [2:0]      opcode,
  input  wire logic [15:0]     address,
  input  wire logic [15:0]     length,
  input  wire logic [7:0]      data_byte,
  input  wire logic            cfg_we,
  input  wire logic [15:0]     cfg_data,
  output sesq_pkg::job_t       job,
  output logic                 job_valid
);

  sesq_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [15:0] left_total_r, left_total_nxt;
  logic [sesq_pkg::PAGE_AW-1:0] left_chunk_r, left_chunk_nxt;
  logic [15:0] poll_count_r, poll_count_nxt;
  logic        timeout_r, timeout_nxt;
  logic [15:0] poll_limit_r;

  logic [15:0] sel_addr;
  logic [15:0] sel_total;
  logic [sesq_pkg::PAGE_AW:0] room;
  logic [sesq_pkg::PAGE_AW:0] chunk;
  logic [15:0] chunk_ext;
  logic        is_idle;

  assign is_idle   = (phase_r == sesq_pkg::PH_IDLE);
  assign sel_addr  = is_idle ? address : cur_addr_r;
  assign sel_total = is_idle ? length : left_total_r;
  assign room      = (sesq_pkg::PAGE_AW+1)'(sesq_pkg::PAGE_BYTES)
                     - {1'b0, sel_addr[sesq_pkg::PAGE_AW-1:0]};
  assign chunk     = (sel_total < 16'(room)) ? sel_total[sesq_pkg::PAGE_AW:0] : room;
  assign chunk_ext = 16'(chunk);

  always_comb begin
    phase_nxt      = phase_r;
    cur_addr_nxt   = cur_addr_r;
    left_total_nxt = left_total_r;
    left_chunk_nxt = left_chunk_r;
    poll_count_nxt = poll_count_r;
    timeout_nxt    = timeout_r;
    job_valid      = 1'b0;
    job.kind       = sesq_pkg::JK_DONE;
    job.addr       = sel_addr;
    job.data       = data_byte;
    case (opcode)
      sesq_pkg::OP_WRITE_REQ: begin
        if (is_idle) begin
          job_valid    = 1'b1;
          timeout_nxt  = 1'b0;
          cur_addr_nxt = address;
          left_total_nxt = length;
          if (length != 16'd0) begin
            job.kind       = sesq_pkg::JK_WCHUNK;
            left_total_nxt = length - chunk_ext;
            cur_addr_nxt   = address + chunk_ext;
            left_chunk_nxt = sesq_pkg::PAGE_AW'(chunk - 1'b1);
            phase_nxt      = sesq_pkg::PH_WDATA;
          end
        end
      end
      sesq_pkg::OP_READ_REQ: begin
        if (is_idle) begin
          job_valid      = 1'b1;
          timeout_nxt    = 1'b0;
          cur_addr_nxt   = address;
          left_total_nxt = length;
          if (length != 16'd0) begin
            job.kind  = sesq_pkg::JK_RDSTART;
            phase_nxt = sesq_pkg::PH_RDATA;
          end
        end
      end
      sesq_pkg::OP_WRSR_REQ: begin
        if (is_idle) begin
          job_valid   = 1'b1;
          timeout_nxt = 1'b0;
          job.kind    = sesq_pkg::JK_WRSR;
        end
      end
      sesq_pkg::OP_DATA: begin
        if (phase_r == sesq_pkg::PH_WDATA) begin
          job_valid = 1'b1;
          if (left_chunk_r != '0) begin
            job.kind       = sesq_pkg::JK_WDATA;
            left_chunk_nxt = left_chunk_r - 1'b1;
          end else begin
            job.kind       = sesq_pkg::JK_WDATA_END;
            poll_count_nxt = 16'd0;
            phase_nxt      = sesq_pkg::PH_WPOLL;
          end
        end
      end
      sesq_pkg::OP_RX: begin
        if (phase_r == sesq_pkg::PH_WPOLL) begin
          job_valid = 1'b1;
          if (data_byte[0] && (poll_count_r < poll_limit_r)) begin
            job.kind       = sesq_pkg::JK_POLL;
            poll_count_nxt = poll_count_r + 16'd1;
          end else begin
            if (data_byte[0]) begin
              timeout_nxt = 1'b1;
            end
            if (left_total_r != 16'd0) begin
              job.kind       = sesq_pkg::JK_FIN_NEXT;
              left_total_nxt = left_total_r - chunk_ext;
              cur_addr_nxt   = cur_addr_r + chunk_ext;
              left_chunk_nxt = sesq_pkg::PAGE_AW'(chunk - 1'b1);
              phase_nxt      = sesq_pkg::PH_WDATA;
            end else begin
              job.kind  = sesq_pkg::JK_FIN_DONE;
              phase_nxt = sesq_pkg::PH_IDLE;
            end
          end
        end else if (phase_r == sesq_pkg::PH_RDATA) begin
          job_valid      = 1'b1;
          cur_addr_nxt   = cur_addr_r + 16'd1;
          left_total_nxt = left_total_r - 16'd1;
          if (left_total_r != 16'd1) begin
            job.kind = sesq_pkg::JK_RHOST_MORE;
          end else begin
            job.kind  = sesq_pkg::JK_RHOST_END;
            phase_nxt = sesq_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
    job.timed_out = timeout_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sesq_pkg::PH_IDLE;
      cur_addr_r   <= 16'd0;
      left_total_r <= 16'd0;
      left_chunk_r <= '0;
      poll_count_r <= 16'd0;
      timeout_r    <= 1'b0;
      poll_limit_r <= sesq_pkg::POLL_LIMIT_RESET;
    end else begin
      if (accept) begin
        phase_r      <= phase_nxt;
        cur_addr_r   <= cur_addr_nxt;
        left_total_r <= left_total_nxt;
        left_chunk_r <= left_chunk_nxt;
        poll_count_r <= poll_count_nxt;
        timeout_r    <= timeout_nxt;
      end
      if (cfg_we) begin
        poll_limit_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sesq_jobq.sv =====
// ----------------------------------------------------------------------------
// SPI EEPROM sequencer job queue
// Short first-in first-out queue that decouples the front end from the back
// end.
// ----------------------------------------------------------------------------
`default_nettype none

module sesq_jobq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sesq_pkg::job_t wdata,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output sesq_pkg::job_t      rdata
);

  sesq_pkg::job_t mem_r [sesq_pkg::JOBQ_DEPTH];
  logic [sesq_pkg::JOBQ_AW-1:0] wr_ptr_r;
  logic [sesq_pkg::JOBQ_AW-1:0] rd_ptr_r;
  logic [sesq_pkg::JOBQ_AW:0]   count_r;

  assign full  = (count_r == (sesq_pkg::JOBQ_AW+1)'(sesq_pkg::JOBQ_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sesq_back.sv =====
// ----------------------------------------------------------------------------
// SPI EEPROM sequencer back end
// Expands each queued job into its result words, one word per cycle while the
// output is taken, into a single output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sesq_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sesq_pkg::job_t job,
  input  wire logic           job_empty,
  output logic                job_pop,
  input  wire logic           out_take,
  output logic                out_valid,
  output logic [2:0]          out_action,
  output logic [7:0]          out_spi_byte,
  output logic                out_last,
  output logic                out_timed_out
);

  sesq_pkg::step_t step;
  logic [3:0] idx_r;
  logic       valid_r, valid_nxt;
  logic [2:0] action_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r;
  logic       timed_out_r;
  logic       advance;

  assign step    = sesq_pkg::seq_step(job.kind, idx_r);
  assign advance = !job_empty && (!valid_r || out_take);
  assign job_pop = advance && step.fin;

  always_comb begin
    case (step.src)
      sesq_pkg::SRC_DATA: byte_nxt = job.data;
      sesq_pkg::SRC_AHI:  byte_nxt = job.addr[15:8];
      sesq_pkg::SRC_ALO:  byte_nxt = job.addr[7:0];
      default:            byte_nxt = step.cbyte;
    endcase
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else begin
      valid_r <= valid_nxt;
      if (advance) begin
        idx_r <= step.fin ? 4'd0 : idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action_r    <= step.act;
      byte_r      <= byte_nxt;
      last_r      <= step.fin;
      timed_out_r <= job.timed_out;
    end
  end

  assign out_valid     = valid_r;
  assign out_action    = action_r;
  assign out_spi_byte  = byte_r;
  assign out_last      = last_r;
  assign out_timed_out = timed_out_r;

endmodule

`default_nettype wire

// ===== src/spi_eeprom_transaction_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// SPI EEPROM transaction sequencer
// Turns host requests into chip-select and byte actions for an SPI EEPROM.
// ----------------------------------------------------------------------------
// The front end takes one input word per cycle while its four-entry job queue
// has room. The back end issues one result word per cycle, while results are
// popped, from a single output register; an input word yields from none, for
// an ignored word, up to eleven result words, and that result register sets
// the sustained rate. The poll limit register is written through the cfg
// channel, which is always ready.
`default_nettype none

module spi_eeprom_transaction_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_length,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_action,
  output logic [7:0]       out_spi_byte,
  output logic             out_last,
  output logic             out_timed_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  sesq_pkg::job_t fe_job;
  sesq_pkg::job_t q_job;
  logic fe_job_valid;
  logic accept;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic out_valid;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign out_empty = !out_valid;

  sesq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_opcode),
    .address   (in_address),
    .length    (in_length),
    .data_byte (in_data_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .job       (fe_job),
    .job_valid (fe_job_valid)
  );

  sesq_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept && fe_job_valid),
    .wdata (fe_job),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_job)
  );

  sesq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (q_job),
    .job_empty     (q_empty),
    .job_pop       (q_pop),
    .out_take      (out_pop && out_valid),
    .out_valid     (out_valid),
    .out_action    (out_action),
    .out_spi_byte  (out_spi_byte),
    .out_last      (out_last),
    .out_timed_out (out_timed_out)
  );

endmodule

`default_nettype wire

// ===== src/sesq_checker.sv =====
// ----------------------------------------------------------------------------
// SPI EEPROM sequencer port checker
// Watches the top-level ports for protocol and sequencing errors.
// ----------------------------------------------------------------------------
`default_nettype none

module sesq_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_full,
  input  wire logic        out_empty,
  input  wire logic        out_pop,
  input  wire logic [2:0]  out_action,
  input  wire logic [7:0]  out_spi_byte,
  input  wire logic        out_last
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!in_full && out_empty))
    else $error("queues not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_action)
      && $stable(out_spi_byte) && $stable(out_last)))
    else $error("waiting result word changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_action == sesq_pkg::ACT_DONE)) |-> out_last)
    else $error("request done word not marked last");

  a_ctrl_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && ((out_action == sesq_pkg::ACT_SEL)
      || (out_action == sesq_pkg::ACT_DESEL)
      || (out_action == sesq_pkg::ACT_DONE))) |-> (out_spi_byte == 8'h00))
    else $error("control word carries a non-zero byte");

endmodule

bind spi_eeprom_transaction_sequencer_core sesq_checker u_sesq_checker (.*);

`default_nettype wire
